// ----- rtl/core/hpb_pkg.sv -----
package hpb_pkg;

	// field widths
	localparam int FREQ_W     = 8;
	localparam int LEVEL_W    = 16;
	localparam int HEADING_W  = 16;
	localparam int ELEV_W     = 15;
	localparam int SPEED_W    = 12;
	localparam int SPACING_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_SOUND_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING     = 2'd1;
	localparam logic [SPEED_W-1:0]   SPEED_RESET     = 12'd1500;
	localparam logic [SPACING_W-1:0] SPACING_RESET   = 16'd100;

	// cordic datapath: vectors up to 2^33 in, q30 angles
	localparam int XW = 37;
	localparam int AW = 34;
	localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;
	localparam int SAMPLE_SCALE_TOP = 34;

	// elevation arithmetic
	localparam int DIFF_SHIFT  = 10;
	localparam int SUMW        = 48;
	localparam int SPEED_SCALE = 10;
	localparam int C10_W       = 16;
	localparam int PROD_W      = 40;
	localparam int NUM_SHIFT   = 24;
	localparam int NUM_W       = 64;
	localparam int DEN1_W      = 27;
	localparam int DEN_W       = 43;
	localparam int DIV_W       = 72;
	localparam int QB          = 29;
	localparam int OVF_SHIFT   = 29;
	localparam int SQ_IN_W     = 58;
	localparam int ELEV_SHIFT  = 5;
	localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
	localparam logic [QB-1:0] ARG_ONE  = 29'h1000_0000;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [FREQ_W-1:0]  freq;
		logic [LEVEL_W-1:0] amplitude;
		logic [LEVEL_W-1:0] noise;
		logic               freq_zero;
	} side_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic signed [AW-1:0] atan_q30(input int unsigned i);
		logic signed [AW-1:0] v;
		unique case (i)
			0:  v = 34'sd843314856;
			1:  v = 34'sd497837829;
			2:  v = 34'sd263043836;
			3:  v = 34'sd133525158;
			4:  v = 34'sd67021686;
			5:  v = 34'sd33543515;
			6:  v = 34'sd16775850;
			7:  v = 34'sd8388437;
			8:  v = 34'sd4194282;
			9:  v = 34'sd2097149;
			10: v = 34'sd1048575;
			11: v = 34'sd524287;
			12: v = 34'sd262143;
			13: v = 34'sd131071;
			14: v = 34'sd65535;
			15: v = 34'sd32767;
			16: v = 34'sd16383;
			17: v = 34'sd8191;
			18: v = 34'sd4095;
			19: v = 34'sd2047;
			20: v = 34'sd1023;
			21: v = 34'sd511;
			22: v = 34'sd255;
			23: v = 34'sd127;
			24: v = 34'sd63;
			25: v = 34'sd31;
			26: v = 34'sd15;
			27: v = 34'sd8;
			28: v = 34'sd4;
			29: v = 34'sd2;
			30: v = 34'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/core/hpb_if.sv -----
interface hpb_ping_if #(parameter int SAMPLE_WIDTH = 18);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] ref_real;
	logic signed [SAMPLE_WIDTH-1:0] ref_imag;
	logic signed [SAMPLE_WIDTH-1:0] first_real;
	logic signed [SAMPLE_WIDTH-1:0] first_imag;
	logic signed [SAMPLE_WIDTH-1:0] second_real;
	logic signed [SAMPLE_WIDTH-1:0] second_imag;
	logic [hpb_pkg::FREQ_W-1:0] freq_khz;
	logic [hpb_pkg::LEVEL_W-1:0] amplitude_in;
	logic [hpb_pkg::LEVEL_W-1:0] noise_in;

	modport source (
		output valid, ref_real, ref_imag, first_real, first_imag, second_real, second_imag,
		output freq_khz, amplitude_in, noise_in,
		input ready
	);
	modport sink (
		input valid, ref_real, ref_imag, first_real, first_imag, second_real, second_imag,
		input freq_khz, amplitude_in, noise_in,
		output ready
	);
endinterface

interface hpb_bearing_if;
	logic valid;
	logic ready;
	logic signed [hpb_pkg::HEADING_W-1:0] heading;
	logic [hpb_pkg::ELEV_W-1:0] elevation;
	logic angles_valid;
	logic [hpb_pkg::FREQ_W-1:0] freq_out;
	logic [hpb_pkg::LEVEL_W-1:0] amplitude_out;
	logic [hpb_pkg::LEVEL_W-1:0] noise_out;

	modport source (
		output valid, heading, elevation, angles_valid, freq_out, amplitude_out, noise_out,
		input ready
	);
	modport sink (
		input valid, heading, elevation, angles_valid, freq_out, amplitude_out, noise_out,
		output ready
	);
endinterface

// ----- rtl/core/hpb_front.sv -----
module hpb_front #(
	parameter int SAMPLE_WIDTH = 18
) (
	input  logic clk,
	input  logic arst_n,
	hpb_ping_if.sink ping,
	input  hpb_pkg::q_stat_t qstat,
	output logic push,
	output logic [5:0][SAMPLE_WIDTH-1:0] samples,
	output hpb_pkg::side_t side
);
	logic hold_q;
	logic accept;

	assign ping.ready = !hold_q || !qstat.full;
	assign accept     = ping.valid && ping.ready;
	assign push       = hold_q && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (accept) begin
			hold_q <= 1'b1;
		end else if (push) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samples[0]     <= ping.ref_real;
			samples[1]     <= ping.ref_imag;
			samples[2]     <= ping.first_real;
			samples[3]     <= ping.first_imag;
			samples[4]     <= ping.second_real;
			samples[5]     <= ping.second_imag;
			side.freq      <= ping.freq_khz;
			side.amplitude <= ping.amplitude_in;
			side.noise     <= ping.noise_in;
			// zero frequency means no wavelength, so no elevation
			side.freq_zero <= (ping.freq_khz == '0);
		end
	end
endmodule

// ----- rtl/core/hpb_queue.sv -----
module hpb_queue #(
	parameter int DW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [DW-1:0] wdata,
	input  logic pop,
	output logic [DW-1:0] rdata,
	output hpb_pkg::q_stat_t stat
);
	localparam int DEPTH = hpb_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(DEPTH);

	logic [DW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assign rdata      = mem_q[rd_q];
	assign stat.full  = (cnt_q == (PW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
endmodule

// ----- rtl/core/hpb_cordic.sv -----
module hpb_cordic #(
	parameter int STAGES = 16
) (
	input  logic clk,
	input  logic en,
	input  logic signed [hpb_pkg::XW-1:0] x,
	input  logic signed [hpb_pkg::XW-1:0] y,
	output logic signed [hpb_pkg::AW-1:0] angle
);
	localparam int XW = hpb_pkg::XW;
	localparam int AW = hpb_pkg::AW;
	localparam logic signed [AW-1:0] PI = hpb_pkg::PI_Q30;

	logic signed [XW-1:0] x_s [STAGES+1];
	logic signed [XW-1:0] y_s [STAGES+1];
	logic signed [AW-1:0] z_s [STAGES+1];
	logic zero_s [STAGES+1];
	logic signed [AW-1:0] z_end;

	// left half plane is folded over by a half turn first
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x == '0) && (y == '0);
			if (x < 0) begin
				x_s[0] <= -x;
				y_s[0] <= -y;
				z_s[0] <= (y >= 0) ? PI : -PI;
			end else begin
				x_s[0] <= x;
				y_s[0] <= y;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + hpb_pkg::atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - hpb_pkg::atan_q30(i);
				end
			end
		end
	end

	assign z_end = z_s[STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[STAGES]) begin
				angle <= '0;
			end else if (z_end > PI) begin
				angle <= PI;
			end else if (z_end < -PI) begin
				angle <= -PI;
			end else begin
				angle <= z_end;
			end
		end
	end
endmodule

// ----- rtl/core/hpb_isqrt.sv -----
module hpb_isqrt #(
	parameter int IN_W = 48
) (
	input  logic clk,
	input  logic en,
	input  logic [IN_W-1:0] v,
	output logic [IN_W/2-1:0] root
);
	localparam int RW = IN_W / 2;

	logic [IN_W-1:0] rem_s [RW];
	logic [IN_W-1:0] r_s [RW];

	// one result bit per stage, trial bit walks down by powers of four
	for (genvar k = 0; k < RW; k++) begin : g_step
		localparam logic [IN_W-1:0] BIT = IN_W'(1) << (2 * (RW - 1 - k));
		logic [IN_W-1:0] rem_i;
		logic [IN_W-1:0] r_i;
		logic [IN_W-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_i = v;
			assign r_i   = '0;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign r_i   = r_s[k-1];
		end

		assign trial = r_i + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= trial) begin
					rem_s[k] <= rem_i - trial;
					r_s[k]   <= (r_i >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_i;
					r_s[k]   <= r_i >> 1;
				end
			end
		end
	end

	assign root = r_s[RW-1][RW-1:0];
endmodule

// ----- rtl/core/hpb_back.sv -----
module hpb_back #(
	parameter int SAMPLE_WIDTH = 18,
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [5:0][SAMPLE_WIDTH-1:0] samples,
	input  hpb_pkg::side_t side,
	input  hpb_pkg::q_stat_t qstat,
	output logic pop,
	input  logic [hpb_pkg::SPEED_W-1:0] sound_speed,
	input  logic [hpb_pkg::SPACING_W-1:0] hydrophone_spacing,
	hpb_bearing_if.source bearing
);
	localparam int XW     = hpb_pkg::XW;
	localparam int AW     = hpb_pkg::AW;
	localparam int SUMW   = hpb_pkg::SUMW;
	localparam int RW_D   = SUMW / 2;
	localparam int QB     = hpb_pkg::QB;
	localparam int SQW    = hpb_pkg::SQ_IN_W;
	localparam int RW_S   = SQW / 2;
	localparam int NUM_W  = hpb_pkg::NUM_W;
	localparam int DEN_W  = hpb_pkg::DEN_W;
	localparam int DEN1_W = hpb_pkg::DEN1_W;
	localparam int DIV_W  = hpb_pkg::DIV_W;
	localparam int PROD_W = hpb_pkg::PROD_W;
	localparam int C10_W  = hpb_pkg::C10_W;
	localparam int SCALE  = hpb_pkg::SAMPLE_SCALE_TOP - SAMPLE_WIDTH;
	localparam int DS     = hpb_pkg::DIFF_SHIFT;
	localparam int AB_W   = AW + 1 - DS;
	localparam int LC     = CORDIC_STAGES + 2;
	localparam int HDLY   = 6 + RW_D + QB + RW_S;
	localparam int TOTAL  = 2 * LC + 8 + RW_D + QB + RW_S;
	localparam int OKL    = TOTAL - 2 - LC;
	localparam int SH     = 30 - ANGLE_FRAC_BITS;
	localparam logic signed [AW:0] HALF = (AW+1)'(1 << (SH - 1));
	localparam logic [SQW-1:0] ONE_SQ = SQW'(1) << (2 * (QB - 1));

	logic adv;
	logic out_valid_q;
	logic [TOTAL-2:0] v_s;
	hpb_pkg::side_t side_s [TOTAL-1];

	assign adv = !out_valid_q || bearing.ready;
	assign pop = adv && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s         <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s         <= {v_s[TOTAL-3:0], pop};
			out_valid_q <= v_s[TOTAL-2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side;
			for (int k = 1; k < TOTAL - 1; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// three phases
	logic signed [XW-1:0] px [3];
	logic signed [XW-1:0] py [3];
	logic signed [AW-1:0] phase [3];

	for (genvar c = 0; c < 3; c++) begin : g_phase
		assign px[c] = XW'($signed(samples[2*c])) <<< SCALE;
		assign py[c] = XW'($signed(samples[2*c+1])) <<< SCALE;
		hpb_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
			.clk(clk), .en(adv), .x(px[c]), .y(py[c]), .angle(phase[c])
		);
	end

	// phase differences against the reference
	logic signed [AW:0] d1_w, d2_w, d1_s, d2_s;
	logic ok_d_s;

	assign d1_w = (AW+1)'(phase[1]) - (AW+1)'(phase[0]);
	assign d2_w = (AW+1)'(phase[2]) - (AW+1)'(phase[0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s   <= d1_w;
			d2_s   <= d2_w;
			// cosine of the heading is zero when only d2 vanishes
			ok_d_s <= !side_s[LC-1].freq_zero && !((d2_w == '0) && (d1_w != '0));
		end
	end

	// heading
	logic signed [XW-1:0] hx, hy;
	logic signed [AW-1:0] heading_a;
	logic signed [AW-1:0] hd_l [HDLY];

	assign hx = XW'(d2_s);
	assign hy = XW'(d1_s);

	hpb_cordic #(.STAGES(CORDIC_STAGES)) u_heading (
		.clk(clk), .en(adv), .x(hx), .y(hy), .angle(heading_a)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			hd_l[0] <= heading_a;
			for (int k = 1; k < HDLY; k++) begin
				hd_l[k] <= hd_l[k-1];
			end
		end
	end

	// radius of the difference vector
	logic signed [AB_W-1:0] a_w, b_w;
	logic signed [2*AB_W-1:0] asq_w, bsq_w;
	logic [SUMW-1:0] asq_s, bsq_s, sum_s;
	logic [DEN1_W-1:0] den1_s;
	logic [DEN_W-1:0] den_l [RW_D+1];
	logic [RW_D-1:0] r_d;

	assign a_w   = d1_s[AW:DS];
	assign b_w   = d2_s[AW:DS];
	assign asq_w = a_w * a_w;
	assign bsq_w = b_w * b_w;

	always_ff @(posedge clk) begin
		if (adv) begin
			asq_s    <= asq_w[SUMW-1:0];
			bsq_s    <= bsq_w[SUMW-1:0];
			den1_s   <= DEN1_W'(hpb_pkg::TWO_PI_Q16) * DEN1_W'(side_s[LC].freq);
			sum_s    <= asq_s + bsq_s;
			den_l[0] <= DEN_W'(den1_s) * DEN_W'(hydrophone_spacing);
			for (int k = 1; k <= RW_D; k++) begin
				den_l[k] <= den_l[k-1];
			end
		end
	end

	hpb_isqrt #(.IN_W(SUMW)) u_root_d (
		.clk(clk), .en(adv), .v(sum_s), .root(r_d)
	);

	// numerator and the overflow check ahead of the divider
	logic [C10_W-1:0] c10;
	logic [PROD_W-1:0] prod_w;
	logic [NUM_W-1:0] num_s;
	logic [DEN_W-1:0] den_n_s, den_o_s;
	logic ovf_s, nz_s;
	logic [NUM_W-1:0] rem0_s;

	assign c10    = C10_W'(sound_speed) * C10_W'(hpb_pkg::SPEED_SCALE);
	assign prod_w = PROD_W'(c10) * PROD_W'(r_d);

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s   <= {prod_w, hpb_pkg::NUM_SHIFT'(0)};
			den_n_s <= den_l[RW_D];
			ovf_s   <= {(DEN_W - (NUM_W - hpb_pkg::OVF_SHIFT))'(0),
				num_s[NUM_W-1:hpb_pkg::OVF_SHIFT]} >= den_n_s;
			nz_s    <= (num_s != '0);
			rem0_s  <= num_s;
			den_o_s <= den_n_s;
		end
	end

	// restoring divider, one quotient bit per stage
	logic [NUM_W-1:0] rem_dv [QB];
	logic [QB-1:0] q_dv [QB];
	logic [DEN_W-1:0] den_dv [QB];
	logic ovf_dv [QB];
	logic nz_dv [QB];

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int J = QB - 1 - k;
		logic [NUM_W-1:0] rem_i;
		logic [QB-1:0] q_i;
		logic [DEN_W-1:0] den_i;
		logic ovf_i, nz_i;
		logic [DIV_W-1:0] cmp;
		logic ge;

		if (k == 0) begin : g_first
			assign rem_i = rem0_s;
			assign q_i   = '0;
			assign den_i = den_o_s;
			assign ovf_i = ovf_s;
			assign nz_i  = nz_s;
		end else begin : g_next
			assign rem_i = rem_dv[k-1];
			assign q_i   = q_dv[k-1];
			assign den_i = den_dv[k-1];
			assign ovf_i = ovf_dv[k-1];
			assign nz_i  = nz_dv[k-1];
		end

		assign cmp = DIV_W'(den_i) << J;
		assign ge  = DIV_W'(rem_i) >= cmp;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_dv[k] <= ge ? rem_i - cmp[NUM_W-1:0] : rem_i;
				q_dv[k]   <= q_i | (QB'(ge) << J);
				den_dv[k] <= den_i;
				ovf_dv[k] <= ovf_i;
				nz_dv[k]  <= nz_i;
			end
		end
	end

	// saturated cosine argument and its complement
	logic [QB-1:0] q_f, arg_s, argc_s;
	logic [SQW-1:0] argsq_s, sin_in;
	logic [QB-1:0] al [RW_S];
	logic [RW_S-1:0] s_root;

	assign q_f    = q_dv[QB-1];
	assign sin_in = ONE_SQ - argsq_s;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!nz_dv[QB-1]) begin
				arg_s <= '0;
			end else if (ovf_dv[QB-1] || (q_f > hpb_pkg::ARG_ONE)) begin
				arg_s <= hpb_pkg::ARG_ONE;
			end else begin
				arg_s <= q_f;
			end
			argsq_s <= SQW'(arg_s) * SQW'(arg_s);
			argc_s  <= arg_s;
			al[0]   <= argc_s;
			for (int k = 1; k < RW_S; k++) begin
				al[k] <= al[k-1];
			end
		end
	end

	hpb_isqrt #(.IN_W(SQW)) u_root_s (
		.clk(clk), .en(adv), .v(sin_in), .root(s_root)
	);

	// elevation
	logic signed [XW-1:0] ex, ey;
	logic signed [AW-1:0] elev_a;
	logic ok_l [OKL];

	assign ex = XW'(al[RW_S-1]) << hpb_pkg::ELEV_SHIFT;
	assign ey = XW'(s_root) << hpb_pkg::ELEV_SHIFT;

	hpb_cordic #(.STAGES(CORDIC_STAGES)) u_elev (
		.clk(clk), .en(adv), .x(ex), .y(ey), .angle(elev_a)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_l[0] <= ok_d_s;
			for (int k = 1; k < OKL; k++) begin
				ok_l[k] <= ok_l[k-1];
			end
		end
	end

	// round half up into the output fraction
	logic signed [AW:0] hrnd_w, ernd_w;
	logic signed [AW-1:0] elev_pos;
	logic ok_f;
	hpb_pkg::side_t side_f;

	assign ok_f     = ok_l[OKL-1];
	assign side_f   = side_s[TOTAL-2];
	assign elev_pos = (elev_a < 0) ? '0 : elev_a;
	assign hrnd_w   = ((AW+1)'(hd_l[HDLY-1]) + HALF) >>> SH;
	assign ernd_w   = ((AW+1)'(elev_pos) + HALF) >>> SH;

	always_ff @(posedge clk) begin
		if (adv) begin
			bearing.heading       <= hrnd_w[hpb_pkg::HEADING_W-1:0];
			bearing.elevation     <= ok_f ? ernd_w[hpb_pkg::ELEV_W-1:0] : '0;
			bearing.angles_valid  <= ok_f;
			bearing.freq_out      <= side_f.freq;
			bearing.amplitude_out <= side_f.amplitude;
			bearing.noise_out     <= side_f.noise;
		end
	end

	assign bearing.valid = out_valid_q;
endmodule

// ----- rtl/core/hydrophone_phase_bearing_core.sv -----
// throughput: one ping per cycle while the output is not stalled;
// every cordic, root extractor and divider bit is its own stage
// a four-entry queue parts the input register from the pipeline, which stalls as one on output
// reset: arst_n clears valid flags, queue pointers and sets sound_speed 1500, spacing 100
// no clearing pass after reset
module hydrophone_phase_bearing_core #(
	parameter int SAMPLE_WIDTH = 18,
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	hpb_ping_if.sink ping,
	hpb_bearing_if.source bearing,
	input  logic cfg_we,
	input  logic [hpb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hpb_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int SIDE_W = $bits(hpb_pkg::side_t);
	localparam int SMP_W  = 6 * SAMPLE_WIDTH;
	localparam int DW     = SMP_W + SIDE_W;

	logic [hpb_pkg::SPEED_W-1:0] sound_speed_q;
	logic [hpb_pkg::SPACING_W-1:0] spacing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_speed_q <= hpb_pkg::SPEED_RESET;
			spacing_q     <= hpb_pkg::SPACING_RESET;
		end else if (cfg_we) begin
			if (cfg_index == hpb_pkg::REG_SOUND_SPEED) begin
				sound_speed_q <= cfg_data[hpb_pkg::SPEED_W-1:0];
			end else if (cfg_index == hpb_pkg::REG_SPACING) begin
				spacing_q <= cfg_data[hpb_pkg::SPACING_W-1:0];
			end
		end
	end

	hpb_pkg::q_stat_t qstat;
	logic push, pop;
	logic [5:0][SAMPLE_WIDTH-1:0] f_samples, q_samples;
	hpb_pkg::side_t f_side, q_side;
	logic [DW-1:0] q_rdata;

	hpb_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .ping(ping), .qstat(qstat),
		.push(push), .samples(f_samples), .side(f_side)
	);

	hpb_queue #(.DW(DW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata({f_samples, f_side}),
		.pop(pop), .rdata(q_rdata), .stat(qstat)
	);

	assign q_samples = q_rdata[DW-1 -: SMP_W];
	assign q_side    = hpb_pkg::side_t'(q_rdata[SIDE_W-1:0]);

	hpb_back #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .samples(q_samples), .side(q_side),
		.qstat(qstat), .pop(pop), .sound_speed(sound_speed_q),
		.hydrophone_spacing(spacing_q), .bearing(bearing)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue written while full");

	a_valid_needs_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(bearing.valid && bearing.angles_valid) |-> (bearing.freq_out != '0))
		else $error("angles flagged valid at zero frequency");

	a_invalid_elev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(bearing.valid && !bearing.angles_valid) |-> (bearing.elevation == '0))
		else $error("elevation not cleared on invalid angles");
`endif
endmodule
